@@ hdl/mabf_pkg.sv @@
// Shared types and constants of the multi-axis bin finder.
package mabf_pkg;

    localparam int NUM_COORDS = 6;
    localparam int COORD_W    = 32;
    localparam int INDEX_W    = 36;
    localparam int BINS_W     = 7;
    localparam int AXCNT_W    = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [2:0] REG_AXIS_COUNT = 3'd0;
    localparam logic [2:0] REG_BINS0      = 3'd1;
    localparam logic [2:0] REG_BINS1      = 3'd2;
    localparam logic [2:0] REG_BINS2      = 3'd3;
    localparam logic [2:0] REG_BINS3      = 3'd4;
    localparam logic [2:0] REG_BINS4      = 3'd5;
    localparam logic [2:0] REG_BINS5      = 3'd6;

    typedef enum logic [2:0] {
        L_IDLE  = 3'b001,
        L_PROBE = 3'b010,
        L_DONE  = 3'b100
    } lane_state_t;

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_HOLD = 3'b100
    } merge_state_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic fail;
    } lane_stat_t;

endpackage

@@ hdl/mabf_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module mabf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hdl/mabf_lane.sv @@
// One axis lane: edge memory, range check and binary search of one coordinate.
module mabf_lane #(
    parameter int MAX_BINS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          take,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_BINS+1)-1:0] wr_addr,
    input  logic [mabf_pkg::COORD_W-1:0]  wr_data,
    input  logic signed [mabf_pkg::COORD_W-1:0] coord,
    input  logic [$clog2(MAX_BINS+1)-1:0] nbins,
    output mabf_pkg::lane_stat_t          stat,
    output logic [$clog2(MAX_BINS+1)-1:0] bin
);

    localparam int DEPTH = MAX_BINS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_BINS + 2);

    mabf_pkg::lane_state_t state_reg, state_next;

    logic signed [mabf_pkg::COORD_W-1:0] coord_reg;
    logic signed [mabf_pkg::COORD_W-1:0] edge0_reg;
    logic [PW-1:0] below_reg, below_next;
    logic [PW-1:0] above_reg, above_next;
    logic [PW-1:0] mid_reg, mid_next;
    logic [AW-1:0] bin_reg, bin_next;
    logic          fail_reg, fail_next;

    logic [mabf_pkg::COORD_W-1:0] rdata_a, rdata_b;
    logic [AW-1:0]                raddr_a;
    logic signed [mabf_pkg::COORD_W-1:0] probe_edge, top_edge;

    logic          eq, lt, cont, fail_c;
    logic [PW-1:0] below_n, above_n, mid_n, first_mid, probe_mid;
    logic [PW:0]   sum_n;

    mabf_ram #(
        .WIDTH (mabf_pkg::COORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (nbins),
        .rdata_b (rdata_b)
    );

    assign probe_edge = signed'(rdata_a);
    assign top_edge   = signed'(rdata_b);

    assign eq      = (coord_reg == probe_edge);
    assign lt      = (coord_reg < probe_edge);
    assign below_n = lt ? below_reg : mid_reg;
    assign above_n = lt ? mid_reg : above_reg;
    assign sum_n   = {1'b0, above_n} + {1'b0, below_n};
    assign mid_n   = sum_n[PW:1];
    assign cont    = ((above_n - below_n) > PW'(1));
    assign fail_c  = (coord_reg < edge0_reg) || (coord_reg > top_edge);

    // first probe depends on the bin count only, so idle keeps it on the port
    assign first_mid = (PW'(nbins) + PW'(1)) >> 1;
    assign probe_mid = ((state_reg == mabf_pkg::L_PROBE) && cont) ? mid_n : first_mid;
    assign raddr_a   = AW'(probe_mid - PW'(1));

    always_comb
    begin
        state_next = state_reg;
        below_next = below_reg;
        above_next = above_reg;
        mid_next   = mid_reg;
        bin_next   = bin_reg;
        fail_next  = fail_reg;
        case (state_reg)
            mabf_pkg::L_IDLE:
            begin
                if (start)
                begin
                    below_next = '0;
                    above_next = PW'(nbins) + PW'(1);
                    mid_next   = first_mid;
                    state_next = mabf_pkg::L_PROBE;
                end
            end
            mabf_pkg::L_PROBE:
            begin
                if (eq)
                begin
                    bin_next   = AW'(mid_reg - PW'(1));
                    fail_next  = fail_c;
                    state_next = mabf_pkg::L_DONE;
                end
                else if (!cont)
                begin
                    bin_next   = (below_n != '0) ? AW'(below_n - PW'(1)) : '0;
                    fail_next  = fail_c;
                    state_next = mabf_pkg::L_DONE;
                end
                else
                begin
                    below_next = below_n;
                    above_next = above_n;
                    mid_next   = mid_n;
                end
            end
            mabf_pkg::L_DONE:
            begin
                if (take)
                begin
                    state_next = mabf_pkg::L_IDLE;
                end
            end
            default:
            begin
                state_next = mabf_pkg::L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mabf_pkg::L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        below_reg <= below_next;
        above_reg <= above_next;
        mid_reg   <= mid_next;
        bin_reg   <= bin_next;
        fail_reg  <= fail_next;
        if ((state_reg == mabf_pkg::L_IDLE) && start)
        begin
            coord_reg <= coord;
        end
        if (wr_en && (wr_addr == '0))
        begin
            edge0_reg <= signed'(wr_data);
        end
    end

    assign stat.idle = (state_reg == mabf_pkg::L_IDLE);
    assign stat.done = (state_reg == mabf_pkg::L_DONE);
    assign stat.fail = fail_reg;
    assign bin       = bin_reg;

endmodule

@@ hdl/mabf_merge.sv @@
// Merge stage: range verdict and row-major flattening, with the output register.
module mabf_merge #(
    parameter int NL       = 6,
    parameter int MAX_BINS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mabf_pkg::lane_stat_t          stat [NL],
    input  logic [$clog2(MAX_BINS+1)-1:0] bins_in [NL],
    input  logic [$clog2(MAX_BINS+1)-1:0] nbins [NL],
    input  logic [$clog2(NL+1)-1:0]       nax,
    input  logic                          out_ready,
    output logic                          take,
    output logic                          out_valid,
    output logic                          in_range,
    output logic [mabf_pkg::INDEX_W-1:0]  bin_index
);

    localparam int BW = $clog2(MAX_BINS + 1);
    localparam int NW = $clog2(NL + 1);
    localparam int SW = (NL > 1) ? $clog2(NL) : 1;

    mabf_pkg::merge_state_t state_reg, state_next;

    logic [BW-1:0]                b_reg [NL];
    logic [mabf_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic                         ok_reg, ok_next;
    logic [SW-1:0]                step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         in_range_reg;
    logic [mabf_pkg::INDEX_W-1:0] bin_index_reg;

    logic                                all_done, inside_c, out_free;
    logic [mabf_pkg::INDEX_W+BW-1:0]     prod;
    logic [mabf_pkg::INDEX_W-1:0]        acc;

    // only the lanes of used axes run; the others stay idle
    always_comb
    begin
        all_done = 1'b1;
        inside_c = 1'b1;
        for (int k = 0; k < NL; k++)
        begin
            if (NW'(k) < nax)
            begin
                all_done = all_done & stat[k].done;
                if (stat[k].fail)
                begin
                    inside_c = 1'b0;
                end
            end
        end
    end

    assign prod     = idx_reg * nbins[step_reg];
    assign acc      = prod[mabf_pkg::INDEX_W-1:0] + mabf_pkg::INDEX_W'(b_reg[step_reg]);
    assign out_free = !out_valid_reg || out_ready;
    assign take     = (state_reg == mabf_pkg::M_IDLE) && all_done;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        ok_next        = ok_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            mabf_pkg::M_IDLE:
            begin
                if (all_done)
                begin
                    idx_next   = '0;
                    step_next  = '0;
                    ok_next    = inside_c;
                    state_next = inside_c ? mabf_pkg::M_RUN : mabf_pkg::M_HOLD;
                end
            end
            mabf_pkg::M_RUN:
            begin
                idx_next  = acc;
                step_next = step_reg + SW'(1);
                if (NW'(step_reg) == (nax - NW'(1)))
                begin
                    state_next = mabf_pkg::M_HOLD;
                end
            end
            mabf_pkg::M_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = mabf_pkg::M_IDLE;
                end
            end
            default:
            begin
                state_next = mabf_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mabf_pkg::M_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        ok_reg   <= ok_next;
        step_reg <= step_next;
        if (take)
        begin
            for (int k = 0; k < NL; k++)
            begin
                b_reg[k] <= bins_in[k];
            end
        end
        if ((state_reg == mabf_pkg::M_HOLD) && out_free)
        begin
            in_range_reg  <= ok_reg;
            bin_index_reg <= ok_reg ? idx_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_range  = in_range_reg;
    assign bin_index = bin_index_reg;

endmodule

@@ hdl/multi_axis_bin_finder.sv @@
// Classify item steps: accept, binary-search probes in each used lane, hand-off to the merge
// stage, one multiply-add per used axis (none when out of range), then the output register.
// A new item is accepted once every lane is idle again; the lanes of a classify item go idle
// only when the merge stage takes their bins, later while the merge stage is busy or a result
// waits. Load items are accepted one per cycle while every lane is idle.
// Reset sets axis_count and every bin count to 1; edge memories are not cleared.
module multi_axis_bin_finder #(
    parameter int MAX_AXES = 6,
    parameter int MAX_BINS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mabf_pkg::ADDR_W-1:0]        paddr,
    input  logic [mabf_pkg::DATA_W-1:0]        pwdata,
    output logic [mabf_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [2:0]                         edge_axis,
    input  logic [mabf_pkg::BINS_W-1:0]        edge_slot,
    input  logic signed [mabf_pkg::COORD_W-1:0] edge_value,
    input  logic signed [mabf_pkg::COORD_W-1:0] coord0,
    input  logic signed [mabf_pkg::COORD_W-1:0] coord1,
    input  logic signed [mabf_pkg::COORD_W-1:0] coord2,
    input  logic signed [mabf_pkg::COORD_W-1:0] coord3,
    input  logic signed [mabf_pkg::COORD_W-1:0] coord4,
    input  logic signed [mabf_pkg::COORD_W-1:0] coord5,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               in_range,
    output logic [mabf_pkg::INDEX_W-1:0]       bin_index
);

    localparam int NL = (MAX_AXES < mabf_pkg::NUM_COORDS) ? MAX_AXES : mabf_pkg::NUM_COORDS;
    localparam int BW = $clog2(MAX_BINS + 1);
    localparam int NW = $clog2(NL + 1);
    localparam int CW = (BW > mabf_pkg::BINS_W) ? BW : mabf_pkg::BINS_W;

    logic [mabf_pkg::AXCNT_W-1:0] axis_count_reg;
    logic [mabf_pkg::BINS_W-1:0]  bins_reg [mabf_pkg::NUM_COORDS];

    logic signed [mabf_pkg::COORD_W-1:0] coords [mabf_pkg::NUM_COORDS];
    mabf_pkg::lane_stat_t stat [NL];
    logic [BW-1:0]        lane_bin [NL];
    logic [BW-1:0]        nbins [NL];
    logic [NW-1:0]        nax;
    logic                 cfg_wr, in_acc, load_acc, classify_acc, slot_ok, take;
    logic [CW-1:0]        slot_ext;

    assign coords[0] = coord0;
    assign coords[1] = coord1;
    assign coords[2] = coord2;
    assign coords[3] = coord3;
    assign coords[4] = coord4;
    assign coords[5] = coord5;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg <= mabf_pkg::AXCNT_W'(1);
            for (int k = 0; k < mabf_pkg::NUM_COORDS; k++)
            begin
                bins_reg[k] <= mabf_pkg::BINS_W'(1);
            end
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                mabf_pkg::REG_AXIS_COUNT: axis_count_reg <= pwdata[mabf_pkg::AXCNT_W-1:0];
                mabf_pkg::REG_BINS0:      bins_reg[0] <= pwdata[mabf_pkg::BINS_W-1:0];
                mabf_pkg::REG_BINS1:      bins_reg[1] <= pwdata[mabf_pkg::BINS_W-1:0];
                mabf_pkg::REG_BINS2:      bins_reg[2] <= pwdata[mabf_pkg::BINS_W-1:0];
                mabf_pkg::REG_BINS3:      bins_reg[3] <= pwdata[mabf_pkg::BINS_W-1:0];
                mabf_pkg::REG_BINS4:      bins_reg[4] <= pwdata[mabf_pkg::BINS_W-1:0];
                mabf_pkg::REG_BINS5:      bins_reg[5] <= pwdata[mabf_pkg::BINS_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            mabf_pkg::REG_AXIS_COUNT: prdata = mabf_pkg::DATA_W'(axis_count_reg);
            mabf_pkg::REG_BINS0:      prdata = mabf_pkg::DATA_W'(bins_reg[0]);
            mabf_pkg::REG_BINS1:      prdata = mabf_pkg::DATA_W'(bins_reg[1]);
            mabf_pkg::REG_BINS2:      prdata = mabf_pkg::DATA_W'(bins_reg[2]);
            mabf_pkg::REG_BINS3:      prdata = mabf_pkg::DATA_W'(bins_reg[3]);
            mabf_pkg::REG_BINS4:      prdata = mabf_pkg::DATA_W'(bins_reg[4]);
            mabf_pkg::REG_BINS5:      prdata = mabf_pkg::DATA_W'(bins_reg[5]);
            default:                  prdata = '0;
        endcase
    end

    // clamp the axis count and bin counts into the supported range
    always_comb
    begin
        if (axis_count_reg == '0)
        begin
            nax = NW'(1);
        end
        else if (axis_count_reg > mabf_pkg::AXCNT_W'(NL))
        begin
            nax = NW'(NL);
        end
        else
        begin
            nax = NW'(axis_count_reg);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            if (bins_reg[k] == '0)
            begin
                nbins[k] = BW'(1);
            end
            else if (CW'(bins_reg[k]) > CW'(MAX_BINS))
            begin
                nbins[k] = BW'(MAX_BINS);
            end
            else
            begin
                nbins[k] = BW'(bins_reg[k]);
            end
        end
    end

    // input handshake: take items only while every lane is free
    always_comb
    begin
        in_ready = 1'b1;
        for (int k = 0; k < NL; k++)
        begin
            in_ready = in_ready & stat[k].idle;
        end
    end

    assign in_acc       = in_valid && in_ready;
    assign load_acc     = in_acc && (op == mabf_pkg::OP_LOAD);
    assign classify_acc = in_acc && (op == mabf_pkg::OP_CLASSIFY);
    assign slot_ext     = CW'(edge_slot);
    assign slot_ok      = (slot_ext <= CW'(MAX_BINS));

    for (genvar g = 0; g < NL; g++)
    begin : g_lane
        mabf_lane #(
            .MAX_BINS (MAX_BINS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (classify_acc && (NW'(g) < nax)),
            .take    (take),
            .wr_en   (load_acc && slot_ok && (edge_axis == 3'(g))),
            .wr_addr (BW'(edge_slot)),
            .wr_data (edge_value),
            .coord   (coords[g]),
            .nbins   (nbins[g]),
            .stat    (stat[g]),
            .bin     (lane_bin[g])
        );
    end

    mabf_merge #(
        .NL       (NL),
        .MAX_BINS (MAX_BINS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .bins_in   (lane_bin),
        .nbins     (nbins),
        .nax       (nax),
        .out_ready (out_ready),
        .take      (take),
        .out_valid (out_valid),
        .in_range  (in_range),
        .bin_index (bin_index)
    );

endmodule

@@ hdl/mabf_chk.sv @@
// Port-level checker for the multi-axis bin finder, bound to the top level.
module mabf_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         op,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         in_range,
    input logic [mabf_pkg::INDEX_W-1:0] bin_index
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped before it was taken");

    // drop the index of an out-of-range event
    a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> bin_index == '0)
        else $error("out-of-range item carries a nonzero index");

    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == mabf_pkg::OP_CLASSIFY) |=> !in_ready)
        else $error("input taken while lanes still search");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == mabf_pkg::OP_LOAD) |=> in_ready)
        else $error("load item stalled the input");

endmodule

bind multi_axis_bin_finder mabf_chk u_chk (.*);
